// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the vector normalizer RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted
`define VN_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, disabled while reset is asserted
`define VN_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define VN_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define VN_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/core/vn_pkg.sv =====
// Package for the 3D vector normalizer: widths, stage counts, lane types.
// No dependencies.
package vn_pkg;
	localparam int IN_W   = 16;
	localparam int FRAC   = 14;
	localparam int OUT_W  = FRAC + 2;
	localparam int NLANE  = 3;
	localparam int NBITS  = FRAC + 1;
	localparam int SQ_W   = 2 * IN_W;
	localparam int SUM_W  = SQ_W + 2;
	localparam int TGT_W  = SQ_W + 2 * FRAC;
	localparam int QS_W   = NBITS + SUM_W;
	localparam int CND_W  = 2 * NBITS + SUM_W + 1;
	// front stages, one per quotient bit, output stage
	localparam int NFRONT = 3;
	localparam int NST    = NFRONT + NBITS + 1;
	localparam logic [NBITS-1:0] ONE_Q = NBITS'(1) << FRAC;

	// One lane's state at one quotient-bit stage
	typedef struct packed {
		logic [TGT_W-1:0] p;    // q*q*S so far
		logic [QS_W-1:0]  qs;   // q*S so far
		logic [NBITS-1:0] q;
		logic [TGT_W-1:0] tgt;  // mag*mag*4^FRAC
		logic [SUM_W-1:0] sum;
		logic             neg;
	} lane_st_t;
endpackage

// ===== rtl/core/vn_in_if.sv =====
// Input channel: one vector per transaction, valid/ready handshake.
// Depends on vn_pkg.
interface vn_in_if;
	import vn_pkg::*;
	logic                   valid;
	logic                   ready;
	logic signed [IN_W-1:0] comp_u;
	logic signed [IN_W-1:0] comp_v;
	logic signed [IN_W-1:0] comp_w;
	modport source (output valid, comp_u, comp_v, comp_w, input ready);
	modport sink (input valid, comp_u, comp_v, comp_w, output ready);
endinterface

// ===== rtl/core/vn_out_if.sv =====
// Output channel: one unit vector per transaction, valid/ready handshake.
// Depends on vn_pkg.
interface vn_out_if;
	import vn_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] unit_u;
	logic signed [OUT_W-1:0] unit_v;
	logic signed [OUT_W-1:0] unit_w;
	logic                    was_zero;
	modport source (output valid, unit_u, unit_v, unit_w, was_zero, input ready);
	modport sink (input valid, unit_u, unit_v, unit_w, was_zero, output ready);
endinterface

// ===== rtl/core/vector3_normalize_top.sv =====
// Normalizes a signed 3D vector to a unit vector in Q1.14, rounded toward zero;
// a zero vector yields (0,0,1) with was_zero set. Fully pipelined: one vector per
// cycle unless the output stalls, through 3 front-end stages, one stage per quotient
// bit in each of three parallel lanes and one output stage. Each stage holds only
// when it is full and the stage after it is stalled, so empty slots close up.
// Depends on vn_pkg, vn_in_if, vn_out_if, vn_front, vn_lane, vn_merge.
`include "assert_macros.svh"
module vector3_normalize_top (
	input  logic     clk,
	input  logic     arst_n,
	vn_in_if.sink    vec_in,
	vn_out_if.source vec_out
);
	import vn_pkg::*;

	logic [NST-1:0]   vld_q;
	logic [NST-1:0]   en;
	logic [IN_W-1:0]  comp [NLANE];
	logic [TGT_W-1:0] tgt [NLANE];
	logic [SUM_W-1:0] sum;
	logic [NLANE-1:0] neg3, qneg;
	logic [NBITS-1:0] q [NLANE];
	logic signed [OUT_W-1:0] unit_q [NLANE];
	logic             zero_q;

	// stage enables: a stage loads when empty or when its successor moves
	always_comb begin
		en[NST-1] = !vld_q[NST-1] || vec_out.ready;
		for (int i = NST - 2; i >= 0; i--)
			en[i] = !vld_q[i] || en[i+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0])
				vld_q[0] <= vec_in.valid;
			for (int i = 1; i < NST; i++)
				if (en[i])
					vld_q[i] <= vld_q[i-1];
		end
	end

	assign vec_in.ready = en[0];
	assign comp[0] = vec_in.comp_u;
	assign comp[1] = vec_in.comp_v;
	assign comp[2] = vec_in.comp_w;

	vn_front u_front (
		.clk    (clk),
		.en     (en[NFRONT-1:0]),
		.comp   (comp),
		.tgt_s3 (tgt),
		.sum_s3 (sum),
		.neg_s3 (neg3)
	);

	for (genvar l = 0; l < NLANE; l++) begin : g_lane
		vn_lane u_lane (
			.clk   (clk),
			.en    (en[NFRONT +: NBITS]),
			.tgt   (tgt[l]),
			.sum   (sum),
			.neg   (neg3[l]),
			.q     (q[l]),
			.q_neg (qneg[l])
		);
	end

	vn_merge u_merge (
		.clk    (clk),
		.en     (en[NST-1]),
		.q      (q),
		.neg    (qneg),
		.unit_q (unit_q),
		.zero_q (zero_q)
	);

	assign vec_out.valid    = vld_q[NST-1];
	assign vec_out.unit_u   = unit_q[0];
	assign vec_out.unit_v   = unit_q[1];
	assign vec_out.unit_w   = unit_q[2];
	assign vec_out.was_zero = zero_q;

	// checks
	`VN_ASSERT_IMP(a_zero_vec, clk, arst_n, vec_out.valid && vec_out.was_zero,
		vec_out.unit_u == 0 && vec_out.unit_v == 0 && vec_out.unit_w == OUT_W'(ONE_Q),
		"zero vector result malformed")
	`VN_ASSERT_IMP(a_empty_ready, clk, arst_n, !vld_q[NST-1], vec_in.ready,
		"input blocked with empty output stage")
	`VN_ASSERT_IMP(a_range, clk, arst_n, vec_out.valid,
		vec_out.unit_u <= $signed(OUT_W'(ONE_Q)) && vec_out.unit_u >= -$signed(OUT_W'(ONE_Q)),
		"unit_u out of range")
endmodule

// ===== rtl/core/vn_front.sv =====
// Front end: magnitudes, squares, sum of squares and per-lane targets.
// Depends on vn_pkg. Three pipeline stages, each with its own enable.
module vn_front (
	input  logic                          clk,
	input  logic [vn_pkg::NFRONT-1:0]     en,
	input  logic [vn_pkg::IN_W-1:0]       comp [vn_pkg::NLANE],
	output logic [vn_pkg::TGT_W-1:0]      tgt_s3 [vn_pkg::NLANE],
	output logic [vn_pkg::SUM_W-1:0]      sum_s3,
	output logic [vn_pkg::NLANE-1:0]      neg_s3
);
	import vn_pkg::*;

	logic [IN_W-1:0]  mag_s1 [NLANE];
	logic [NLANE-1:0] neg_s1, neg_s2;
	logic [SQ_W-1:0]  sq_s2 [NLANE];

	// stage 1: sign and magnitude (most negative value maps to 2^(IN_W-1))
	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int i = 0; i < NLANE; i++) begin
				neg_s1[i] <= comp[i][IN_W-1];
				mag_s1[i] <= comp[i][IN_W-1] ? (~comp[i] + IN_W'(1)) : comp[i];
			end
		end
	end

	// stage 2: squares
	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int i = 0; i < NLANE; i++)
				sq_s2[i] <= SQ_W'(mag_s1[i]) * SQ_W'(mag_s1[i]);
			neg_s2 <= neg_s1;
		end
	end

	// stage 3: sum of squares, scaled squares as compare targets
	always_ff @(posedge clk) begin
		if (en[2]) begin
			sum_s3 <= SUM_W'(sq_s2[0]) + SUM_W'(sq_s2[1]) + SUM_W'(sq_s2[2]);
			for (int i = 0; i < NLANE; i++)
				tgt_s3[i] <= TGT_W'(sq_s2[i]) << (2 * FRAC);
			neg_s3 <= neg_s2;
		end
	end
endmodule

// ===== rtl/core/vn_lane.sv =====
// One normalization lane: restoring bit-by-bit search for the largest q with
// q*q*S <= c*c*4^FRAC, one quotient bit per stage, shift-and-add only.
// Depends on vn_pkg.
module vn_lane (
	input  logic                      clk,
	input  logic [vn_pkg::NBITS-1:0]  en,
	input  logic [vn_pkg::TGT_W-1:0]  tgt,
	input  logic [vn_pkg::SUM_W-1:0]  sum,
	input  logic                      neg,
	output logic [vn_pkg::NBITS-1:0]  q,
	output logic                      q_neg
);
	import vn_pkg::*;

	lane_st_t st_q [NBITS];
	lane_st_t init;

	assign init = '{p: '0, qs: '0, q: '0, tgt: tgt, sum: sum, neg: neg};

	for (genvar k = 0; k < NBITS; k++) begin : g_bit
		localparam int B = FRAC - k;
		lane_st_t         prv;
		lane_st_t         nxt;
		logic [CND_W-1:0] cand;
		logic             take;

		if (k == 0) begin : g_first
			assign prv = init;
		end else begin : g_next
			assign prv = st_q[k-1];
		end

		// (q + 2^B)^2 * S = q^2 S + 2^(B+1) qS + 4^B S
		assign cand = CND_W'(prv.p) + (CND_W'(prv.qs) << (B + 1))
			+ (CND_W'(prv.sum) << (2 * B));
		// q never exceeds 1.0: once its top bit is set no further bit is taken
		assign take = !prv.q[FRAC] && (cand <= CND_W'(prv.tgt));

		// next lane state: pass through, or take this quotient bit
		always_comb begin
			nxt = prv;
			if (take) begin
				nxt.p  = TGT_W'(cand);
				nxt.qs = prv.qs + (QS_W'(prv.sum) << B);
				nxt.q  = prv.q | (NBITS'(1) << B);
			end
		end

		always_ff @(posedge clk) begin
			if (en[k])
				st_q[k] <= nxt;
		end
	end

	assign q     = st_q[NBITS-1].q;
	assign q_neg = st_q[NBITS-1].neg;
endmodule

// ===== rtl/core/vn_merge.sv =====
// Merge stage: applies signs, detects the zero vector, registers the result.
// Depends on vn_pkg.
module vn_merge (
	input  logic                           clk,
	input  logic                           en,
	input  logic [vn_pkg::NBITS-1:0]       q [vn_pkg::NLANE],
	input  logic [vn_pkg::NLANE-1:0]       neg,
	output logic signed [vn_pkg::OUT_W-1:0] unit_q [vn_pkg::NLANE],
	output logic                           zero_q
);
	import vn_pkg::*;

	// A zero vector drives every lane to 1.0; no real vector can do that.
	logic zero;
	assign zero = (q[0] == ONE_Q) && (q[1] == ONE_Q) && (q[2] == ONE_Q);

	always_ff @(posedge clk) begin
		if (en) begin
			zero_q <= zero;
			for (int i = 0; i < NLANE; i++) begin
				if (zero)
					unit_q[i] <= (i == NLANE - 1) ? OUT_W'(ONE_Q) : '0;
				else if (neg[i])
					unit_q[i] <= -OUT_W'(q[i]);
				else
					unit_q[i] <= OUT_W'(q[i]);
			end
		end
	end
endmodule

// ===== test/tb_vector3_normalize_top.sv =====
// Testbench for vector3_normalize_top: random and directed vectors, checked
// against an exact integer normalization predictor.
// Depends on vn_pkg, vn_in_if, vn_out_if and the normalizer RTL.
`timescale 1ns / 1ps
module tb_vector3_normalize_top;
	import vn_pkg::*;

	typedef struct {
		logic signed [IN_W-1:0] u, v, w;
	} vec_t;

	typedef struct {
		logic [OUT_W-1:0] u, v, w;
		logic             zero;
	} unit_t;

	localparam int LAT = NST;
	localparam longint LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	vn_in_if  in_ch();
	vn_out_if out_ch();

	vector3_normalize_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.vec_in  (in_ch.sink),
		.vec_out (out_ch.source)
	);

	always #4 clk = ~clk;

	vec_t   pending[$];
	unit_t  expected_units[$];
	int     mismatches = 0;
	longint cycles = 0;
	bit     quiet = 0;
	int     send_gap = 0;
	int     recv_gap = 0;

	// Largest q in [0, 2^FRAC] with q*q*sum <= mag*mag*4^FRAC
	function automatic logic [NBITS-1:0] unit_mag(input logic [IN_W:0] mag,
			input logic [SUM_W-1:0] sum);
		logic [127:0] goal;
		logic [NBITS-1:0] q;
		logic [NBITS-1:0] t;
		goal = (128'(mag) * 128'(mag)) << (2 * FRAC);
		q = '0;
		for (int b = FRAC; b >= 0; b--) begin
			t = q | (NBITS'(1) << b);
			if (t <= ONE_Q && 128'(t) * 128'(t) * 128'(sum) <= goal)
				q = t;
		end
		return q;
	endfunction

	function automatic unit_t normalize(input vec_t x);
		unit_t r;
		logic [IN_W:0] m[3];
		logic neg[3];
		logic [SUM_W-1:0] s;
		logic [NBITS-1:0] q;
		logic [OUT_W-1:0] o[3];
		logic signed [IN_W-1:0] c[3];
		c[0] = x.u; c[1] = x.v; c[2] = x.w;
		s = '0;
		for (int i = 0; i < 3; i++) begin
			neg[i] = c[i][IN_W-1];
			m[i] = neg[i] ? -{c[i][IN_W-1], c[i]} : {1'b0, c[i]};
			s += SUM_W'(m[i]) * SUM_W'(m[i]);
		end
		if (s == 0) begin
			r.u = '0; r.v = '0; r.w = OUT_W'(ONE_Q); r.zero = 1'b1;
			return r;
		end
		for (int i = 0; i < 3; i++) begin
			q = unit_mag(m[i], s);
			o[i] = neg[i] ? -OUT_W'(q) : OUT_W'(q);
		end
		r.u = o[0]; r.v = o[1]; r.w = o[2]; r.zero = 1'b0;
		return r;
	endfunction

	function automatic logic signed [IN_W-1:0] rand_comp();
		case ($urandom_range(0, 5))
			0: return IN_W'($urandom_range(0, 6)) - 3;
			1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			2: return IN_W'($urandom_range(0, 255)) - 128;
			default: return IN_W'($urandom);
		endcase
	endfunction

	task automatic add_vec(input int u, input int v, input int w);
		vec_t x;
		x.u = IN_W'(u); x.v = IN_W'(v); x.w = IN_W'(w);
		pending.push_back(x);
	endtask

	// Driver: present the next vector, with random idle bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.comp_u <= '0;
			in_ch.comp_v <= '0;
			in_ch.comp_w <= '0;
			send_gap <= 0;
		end else begin
			// the accepted transaction leaves the queue here
			if (in_ch.valid && in_ch.ready) begin
				expected_units.push_back(normalize('{in_ch.comp_u, in_ch.comp_v,
					in_ch.comp_w}));
				void'(pending.pop_front());
			end
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				in_ch.valid <= 1'b0;
			end else if (!quiet && (!in_ch.valid || in_ch.ready)
					&& $urandom_range(0, 9) == 0) begin
				send_gap <= $urandom_range(1, 8);
				in_ch.valid <= 1'b0;
			end else if (!in_ch.valid || in_ch.ready) begin
				if (pending.size() > 0) begin
					vec_t nx;
					nx = pending[0];
					in_ch.valid <= 1'b1;
					in_ch.comp_u <= nx.u;
					in_ch.comp_v <= nx.v;
					in_ch.comp_w <= nx.w;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: stall the output at random, compare each transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			recv_gap <= 0;
		end else begin
			cycles <= cycles + 1;
			if (out_ch.valid && out_ch.ready) begin
				if (expected_units.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result %0d %0d %0d %0b", out_ch.unit_u,
							out_ch.unit_v, out_ch.unit_w, out_ch.was_zero);
				end else begin
					unit_t e;
					e = expected_units.pop_front();
					if (e.u !== out_ch.unit_u || e.v !== out_ch.unit_v
							|| e.w !== out_ch.unit_w || e.zero !== out_ch.was_zero) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp %0d %0d %0d %0b got %0d %0d %0d %0b",
								$signed(e.u), $signed(e.v), $signed(e.w), e.zero,
								out_ch.unit_u, out_ch.unit_v, out_ch.unit_w,
								out_ch.was_zero);
					end
				end
			end
			if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				out_ch.ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				recv_gap <= $urandom_range(1, 8);
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// Timeout
	always @(posedge clk) begin
		if (cycles > LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		// directed: extremes, zero vector, single-axis saturation
		add_vec(0, 0, 0);
		add_vec(1, 0, 0);
		add_vec(0, -1, 0);
		add_vec(0, 0, -32768);
		add_vec(-32768, 0, 0);
		add_vec(32767, 0, 0);
		add_vec(-32768, -32768, -32768);
		add_vec(32767, 32767, 32767);
		add_vec(-32768, 32767, -32768);
		add_vec(1, 1, 1);
		add_vec(-1, -1, -1);
		add_vec(3, 4, 0);
		add_vec(0, -3, 4);
		add_vec(1, 32767, 0);
		add_vec(-1, 0, -32768);
		add_vec(2, -2, 1);
		add_vec(0, 0, 0);
		add_vec(21845, -10922, 5461);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		for (int n = 0; n < 1400; n++) begin
			vec_t x;
			x.u = rand_comp(); x.v = rand_comp(); x.w = rand_comp();
			if ($urandom_range(0, 30) == 0) begin
				x.u = '0; x.v = '0; x.w = '0;
			end
			pending.push_back(x);
			if (n == 1150)
				quiet = 1;
			while (pending.size() > 16)
				@(posedge clk);
		end
		while (pending.size() > 0)
			@(posedge clk);
		while (expected_units.size() > 0)
			@(posedge clk);
		repeat (LAT + 10) @(posedge clk);
		if (mismatches == 0 && expected_units.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/vn_pkg.sv
rtl/core/vn_in_if.sv
rtl/core/vn_out_if.sv
rtl/core/vn_front.sv
rtl/core/vn_lane.sv
rtl/core/vn_merge.sv
rtl/core/vector3_normalize_top.sv
test/tb_vector3_normalize_top.sv
